// File: src/assc_pkg.sv
// ----------------------------------------------------------------------------
// assc_pkg: shared types and constants of the adaptive step size controller
// Field widths, register indexes, reset values and output limits.
// ----------------------------------------------------------------------------
package assc_pkg;

    // Field widths.
    localparam int STEP_W     = 31;
    localparam int VALUE_W    = 32;
    localparam int OSC_W      = 16;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INC_THRESH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REL_MODE     = 3'd4;

    // Register reset values.
    localparam logic [STEP_W-1:0] INIT_STEP_RST = 31'd65536;
    localparam logic [THR_W-1:0]  INC_THRESH_RST = 8'd4;
    localparam logic [STEP_W-1:0] MIN_STEP_RST  = 31'd1;
    localparam logic [STEP_W-1:0] MAX_STEP_RST  = 31'h7FFF_FFFF;

    // Width of the signed additive output range, at most 32 bits.
    localparam int STEP_WIDTH = 32;
    localparam int SAT_BITS   = (STEP_WIDTH < 32) ? STEP_WIDTH : 32;
    localparam logic [VALUE_W:0] SAT_HI  = 33'((64'd1 << (SAT_BITS - 1)) - 64'd1);
    localparam logic [VALUE_W:0] SAT_NEG = SAT_HI + 33'd1;

    // Upper limit of a relative factor.
    localparam logic [VALUE_W:0] FACTOR_MAX = 33'h0_7FFF_FFFF;

    // Limits that shape the step size update.
    typedef struct packed {
        logic [THR_W-1:0]  inc_thresh;
        logic [STEP_W-1:0] step_floor;
        logic [STEP_W-1:0] step_ceil;
    } assc_cfg_t;

endpackage

// File: src/adaptive_step_size_controller.sv
// Flow: an accepted transaction passes through S_LOAD, then S_DIV in relative
// mode with a downward direction, then S_HOLD until the output register is free.
// in_stall holds off a new transaction until the last one has left S_HOLD; the
// bit-serial divider in S_DIV produces one quotient bit per cycle.
// Reset: asynchronous, active low; registers take their reset values and the
// step size starts at 65536.
// ----------------------------------------------------------------------------
// adaptive_step_size_controller: doubling and halving step size controller
// Configuration registers, sequencing, result formatting and output register.
// ----------------------------------------------------------------------------
module adaptive_step_size_controller
    import assc_pkg::*;
#(
    parameter int FRAC_BITS       = 16,
    parameter int RUN_COUNT_WIDTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  direction_up,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [VALUE_W-1:0] step_value,
    output logic [STEP_W-1:0]     current_step,
    output logic [OSC_W-1:0]      oscillation_count
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_HOLD = 4'b1000
    } assc_state_t;

    assc_state_t state_reg, state_next;

    assc_cfg_t         cfg_reg;
    logic              rel_mode_reg;
    logic              up_reg;

    logic              out_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [STEP_W-1:0] cur_step_reg;
    logic [OSC_W-1:0]  osc_out_reg;

    logic              accept;
    logic              out_free;
    logic              reload;
    logic              div_start;
    logic              div_done;
    logic [FRAC_BITS:0] quotient;
    logic [STEP_W-1:0] step_now;
    logic [OSC_W-1:0]  osc_now;
    logic [VALUE_W:0]  mag;
    logic [VALUE_W:0]  factor;
    logic [VALUE_W:0]  signed_ext;
    logic [VALUE_W-1:0] value_w;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign reload   = cfg_we && (cfg_index == REG_INITIAL_STEP);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inc_thresh <= INC_THRESH_RST;
            cfg_reg.step_floor <= MIN_STEP_RST;
            cfg_reg.step_ceil  <= MAX_STEP_RST;
            rel_mode_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INC_THRESH: cfg_reg.inc_thresh <= cfg_data[THR_W-1:0];
                REG_MIN_STEP:   cfg_reg.step_floor <= cfg_data;
                REG_MAX_STEP:   cfg_reg.step_ceil  <= cfg_data;
                REG_REL_MODE:   rel_mode_reg       <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Step size state.
    assc_step_unit #(
        .RUN_COUNT_WIDTH (RUN_COUNT_WIDTH)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .reload     (reload),
        .init_value (cfg_data),
        .cfg        (cfg_reg),
        .fire       (accept),
        .dir_up     (direction_up),
        .step_now   (step_now),
        .osc_now    (osc_now)
    );

    // Reciprocal for the downward relative factor.
    assign div_start = (state_reg == S_LOAD) && rel_mode_reg && !up_reg;

    assc_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .step     (step_now),
        .done     (div_done),
        .quotient (quotient)
    );

    // Result formatting; the quotient stays well below the factor limit.
    always_comb
    begin
        mag    = {2'b00, step_now};
        factor = (33'(1) << FRAC_BITS) + mag;
        if (up_reg)
        begin
            signed_ext = (mag > SAT_HI) ? SAT_HI : mag;
        end
        else
        begin
            signed_ext = (mag > SAT_NEG) ? (33'd0 - SAT_NEG) : (33'd0 - mag);
        end

        if (!rel_mode_reg)
        begin
            value_w = signed_ext[VALUE_W-1:0];
        end
        else if (up_reg)
        begin
            value_w = (factor > FACTOR_MAX) ? FACTOR_MAX[VALUE_W-1:0] : factor[VALUE_W-1:0];
        end
        else
        begin
            value_w = VALUE_W'(quotient);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = div_start ? S_DIV : S_HOLD;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_HOLD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Direction of the transaction in flight.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_reg <= direction_up;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_HOLD) && out_free)
        begin
            value_reg    <= value_w;
            cur_step_reg <= step_now;
            osc_out_reg  <= osc_now;
        end
    end

    assign out_valid         = out_valid_reg;
    assign step_value        = value_reg;
    assign current_step      = cur_step_reg;
    assign oscillation_count = osc_out_reg;

endmodule

// File: src/assc_step_unit.sv
// ----------------------------------------------------------------------------
// assc_step_unit: step size state and its update rule
// Holds the step size, run count, previous direction and oscillation count,
// and applies halving on reversal or doubling after a long run.
// ----------------------------------------------------------------------------
module assc_step_unit
    import assc_pkg::*;
#(
    parameter int RUN_COUNT_WIDTH = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              reload,
    input  logic [STEP_W-1:0] init_value,
    input  assc_cfg_t         cfg,
    input  logic              fire,
    input  logic              dir_up,
    output logic [STEP_W-1:0] step_now,
    output logic [OSC_W-1:0]  osc_now
);

    localparam int CMP_W = (RUN_COUNT_WIDTH > THR_W) ? RUN_COUNT_WIDTH : THR_W;
    localparam logic [RUN_COUNT_WIDTH-1:0] RUN_MAX = '1;
    localparam logic [OSC_W-1:0]           OSC_MAX = '1;

    logic [STEP_W-1:0]          step_reg, step_next;
    logic [RUN_COUNT_WIDTH-1:0] run_reg, run_next;
    logic                       last_reg;
    logic [OSC_W-1:0]           osc_reg, osc_next;

    logic                       first_item;
    logic                       reversal;
    logic                       osc_hit;
    logic [RUN_COUNT_WIDTH-1:0] run_adv;
    logic [STEP_W-1:0]          step_half;
    logic [STEP_W:0]            step_dbl;

    // Update rule for one transaction.
    always_comb
    begin
        first_item = (run_reg == '0);
        reversal   = (dir_up != last_reg);
        osc_hit    = 1'b0;
        step_half  = step_reg >> 1;
        step_dbl   = {step_reg, 1'b0};
        step_next  = step_reg;

        if (reversal)
        begin
            run_adv = RUN_COUNT_WIDTH'(1);
        end
        else if (run_reg < RUN_MAX)
        begin
            run_adv = run_reg + RUN_COUNT_WIDTH'(1);
        end
        else
        begin
            run_adv = run_reg;
        end
        run_next = run_adv;

        if (reversal && !first_item)
        begin
            if (step_reg == cfg.step_floor)
            begin
                osc_hit = 1'b1;
            end
            else if (step_half < cfg.step_floor)
            begin
                step_next = cfg.step_floor;
            end
            else
            begin
                step_next = step_half;
            end
        end
        else if ((CMP_W'(run_adv) >= CMP_W'(cfg.inc_thresh)) && (step_reg < cfg.step_ceil))
        begin
            if (step_dbl > {1'b0, cfg.step_ceil})
            begin
                step_next = cfg.step_ceil;
            end
            else
            begin
                step_next = step_dbl[STEP_W-1:0];
            end
            run_next = run_adv >> 1;
        end

        if (!osc_hit)
        begin
            osc_next = '0;
        end
        else if (osc_reg < OSC_MAX)
        begin
            osc_next = osc_reg + OSC_W'(1);
        end
        else
        begin
            osc_next = osc_reg;
        end
    end

    // State registers; a write of the initial step reloads everything.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= INIT_STEP_RST;
            run_reg  <= '0;
            last_reg <= 1'b0;
            osc_reg  <= '0;
        end
        else if (reload)
        begin
            step_reg <= init_value;
            run_reg  <= '0;
            last_reg <= 1'b0;
            osc_reg  <= '0;
        end
        else if (fire)
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            last_reg <= dir_up;
            osc_reg  <= osc_next;
        end
    end

    assign step_now = step_reg;
    assign osc_now  = osc_reg;

endmodule

// File: src/assc_divider.sv
// ----------------------------------------------------------------------------
// assc_divider: bit-serial reciprocal of the relative factor
// Restoring division of 1.0 squared plus half the divisor by 1.0 plus the
// step, giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
module assc_divider
    import assc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [STEP_W-1:0] step,
    output logic              done,
    output logic [FRAC_BITS:0] quotient
);

    localparam int DEN_W = STEP_W + 1;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int NUM_W = (2 * FRAC_BITS + 2 > DEN_W) ? 2 * FRAC_BITS + 2 : DEN_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   num_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DEN_W-1:0] den_w;
    logic [NUM_W-1:0] num_w;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Divisor and rounded numerator from the step size.
    always_comb
    begin
        den_w = (DEN_W'(1) << FRAC_BITS) + DEN_W'(step);
        num_w = (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(den_w >> 1);
        trial = {rem_reg, num_reg[Q_W-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Busy flag and bit counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(Q_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Shift and subtract datapath; the upper numerator bits preload the
    // remainder because the quotient never exceeds one plus the fraction.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den_w;
            rem_reg <= DEN_W'(num_w >> Q_W);
            num_reg <= num_w[Q_W-1:0];
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[Q_W-2:0], fits};
        end
    end

    assign done     = busy_reg && (cnt_reg == CNT_W'(1));
    assign quotient = quo_reg;

endmodule
